### rtl/joystick_axis_map_direction_latch_unit_assert.svh
// Assertion shorthands shared by jamdl_ctrl and jamdl_dp.
// Each expects clk and arst_n in scope.
`ifndef JOYSTICK_AXIS_MAP_DIRECTION_LATCH_UNIT_ASSERT_SVH
`define JOYSTICK_AXIS_MAP_DIRECTION_LATCH_UNIT_ASSERT_SVH

// same-cycle implication
`define JAMDL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JAMDL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/jamdl_pkg.sv
package jamdl_pkg;

	// field widths
	localparam int RAW_W     = 10;
	localparam int AXIS_W    = 16;
	localparam int DIR_W     = 3;
	localparam int CFG_IDX_W = 3;

	// signed offset raw - centre + limit, and its magnitude
	localparam int OFS_W  = RAW_W + 2;
	// signed span hi - lo + 1; magnitude takes SPAN_W - 1 bits
	localparam int SPAN_W = AXIS_W + 2;

	// dividend magnitude: 1023 * 65536 < 2**26
	localparam int DVD_W        = 26;
	localparam int RADIX_BITS   = 2;
	localparam int FINE_STEPS   = DVD_W / RADIX_BITS;
	// coarse span is 11: 1023 * 11 < 2**14
	localparam int COARSE_W     = 14;
	localparam int COARSE_STEPS = COARSE_W / RADIX_BITS;
	localparam int COARSE_SHIFT = DVD_W - COARSE_W;
	localparam int CNT_W        = 4;

	// quotient and sum widths
	localparam int QUO_W = DVD_W + 1;
	localparam int SUM_W = DVD_W + 2;

	localparam logic [RAW_W-1:0]         RAW_MAX   = 10'd1023;
	localparam logic signed [AXIS_W-1:0] COARSE_LO = -16'sd5;
	localparam logic signed [AXIS_W-1:0] COARSE_HI = 16'sd5;
	localparam logic signed [AXIS_W-1:0] AXIS_NEG_MAX = -16'sd32768;
	localparam logic signed [AXIS_W-1:0] AXIS_POS_MAX = 16'sd32767;

	// coarse values fit in 4 bits signed
	localparam int CRS_W = 4;
	localparam logic signed [CRS_W-1:0] TRIP_HI = 4'sd3;
	localparam logic signed [CRS_W-1:0] TRIP_LO = -4'sd3;
	localparam logic signed [CRS_W-1:0] CRS_MAX = 4'sd5;
	localparam logic signed [CRS_W-1:0] CRS_MIN = -4'sd5;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_CENTER  = 3'd0,
		CFG_Y_CENTER  = 3'd1,
		CFG_X_FLIP    = 3'd2,
		CFG_Y_FLIP    = 3'd3,
		CFG_RANGE_MIN = 3'd4,
		CFG_RANGE_MAX = 3'd5
	} cfg_idx_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_NONE   = 3'd0,
		DIR_LEFT   = 3'd1,
		DIR_RIGHT  = 3'd2,
		DIR_DOWN   = 3'd3,
		DIR_UP     = 3'd4,
		DIR_SELECT = 3'd5
	} dir_t;

	// one mapping pass of the shared arithmetic
	typedef enum logic [1:0] {
		OP_X_FINE   = 2'd0,
		OP_Y_FINE   = 2'd1,
		OP_X_COARSE = 2'd2,
		OP_Y_COARSE = 2'd3
	} axis_op_t;

	typedef struct packed {
		logic     capture;
		logic     prep;
		logic     mul;
		logic     div_step;
		logic     add;
		logic     clamp;
		logic     emit;
		axis_op_t op;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic out_free;
	} stat_t;

endpackage

### rtl/joystick_axis_map_direction_latch_unit.sv
// Two-axis joystick mapper with a latched digital direction. A sample beat
// (kind 0) maps X and Y around their calibrated centres onto the configured
// output range and updates the pending direction from a coarse -5..5 map,
// or latches it when both coarse values are 0 and select is high; a read
// beat (kind 1) returns the latched direction and consumes it. One result
// beat per input beat. All four axis maps share one divider that retires
// two quotient bits per cycle; each map runs prep, multiply, divide steps,
// add and clamp (reads skip the maps); new beats are accepted only in idle.
// The output register lets a new beat be accepted while a result waits; the
// result cycle of the next beat stalls until that register is taken.
// Register writes are taken every cycle and must be issued while idle.
module joystick_axis_map_direction_latch_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   kind,
	input  logic [jamdl_pkg::RAW_W-1:0]            x_raw,
	input  logic [jamdl_pkg::RAW_W-1:0]            y_raw,
	input  logic                                   select_level,
	// register write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [jamdl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [jamdl_pkg::AXIS_W-1:0]           cfg_data,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [jamdl_pkg::AXIS_W-1:0]    x_axis,
	output logic signed [jamdl_pkg::AXIS_W-1:0]    y_axis,
	output logic [jamdl_pkg::DIR_W-1:0]            direction
);

	jamdl_pkg::cmd_t  cmd;
	jamdl_pkg::stat_t stat;

	// sequencer
	jamdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, state and output register
	jamdl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.x_raw        (x_raw),
		.y_raw        (y_raw),
		.select_level (select_level),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.x_axis       (x_axis),
		.y_axis       (y_axis),
		.direction    (direction)
	);

endmodule

### rtl/jamdl_ctrl.sv
`include "joystick_axis_map_direction_latch_unit_assert.svh"

module jamdl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  jamdl_pkg::stat_t    stat,
	output jamdl_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_ADD,
		ST_CLAMP,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	jamdl_pkg::axis_op_t             op_q;
	logic [jamdl_pkg::CNT_W-1:0]     cnt_q;
	logic                            coarse;

	assign coarse = (op_q == jamdl_pkg::OP_X_COARSE) || (op_q == jamdl_pkg::OP_Y_COARSE);

	// commands decoded from state
	always_comb begin
		cmd          = '0;
		cmd.op       = op_q;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.prep     = (state_q == ST_PREP);
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.add      = (state_q == ST_ADD);
		cmd.clamp    = (state_q == ST_CLAMP);
		cmd.emit     = (state_q == ST_EMIT) && stat.out_free;
	end

	assign in_ready = (state_q == ST_IDLE);

	// sequencer: four mapping passes per sample, reads go straight out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= jamdl_pkg::OP_X_FINE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PREP;
						op_q    <= jamdl_pkg::OP_X_FINE;
					end
				end
				ST_PREP: begin
					if (stat.kind) state_q <= ST_EMIT;
					else state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
					if (coarse) cnt_q <= jamdl_pkg::CNT_W'(jamdl_pkg::COARSE_STEPS - 1);
					else cnt_q <= jamdl_pkg::CNT_W'(jamdl_pkg::FINE_STEPS - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) state_q <= ST_ADD;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_ADD: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (op_q == jamdl_pkg::OP_Y_COARSE) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_PREP;
						op_q    <= jamdl_pkg::axis_op_t'(op_q + 2'd1);
					end
				end
				ST_EMIT: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`JAMDL_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready held after accept")
	`JAMDL_ASSERT_NXT(a_emit_idle, cmd.emit, in_ready, "not idle after result beat")
	`JAMDL_ASSERT_IMP(a_capture_idle, cmd.capture, in_ready, "capture outside idle")

endmodule

### rtl/jamdl_dp.sv
`include "joystick_axis_map_direction_latch_unit_assert.svh"

module jamdl_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  jamdl_pkg::cmd_t                        cmd,
	output jamdl_pkg::stat_t                       stat,
	// input item
	input  logic                                   kind,
	input  logic [jamdl_pkg::RAW_W-1:0]            x_raw,
	input  logic [jamdl_pkg::RAW_W-1:0]            y_raw,
	input  logic                                   select_level,
	// register writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [jamdl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [jamdl_pkg::AXIS_W-1:0]           cfg_data,
	// result
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [jamdl_pkg::AXIS_W-1:0]    x_axis,
	output logic signed [jamdl_pkg::AXIS_W-1:0]    y_axis,
	output logic [jamdl_pkg::DIR_W-1:0]            direction
);

	// configuration
	logic [jamdl_pkg::RAW_W-1:0]         x_center_q, y_center_q;
	logic                                x_flip_q, y_flip_q;
	logic signed [jamdl_pkg::AXIS_W-1:0] range_min_q, range_max_q;

	// captured item
	logic                                kind_q;
	logic [jamdl_pkg::RAW_W-1:0]         x_raw_q, y_raw_q;
	logic                                sel_lvl_q;

	// arithmetic registers
	logic [jamdl_pkg::RAW_W-1:0]         ofs_mag_q;
	logic [jamdl_pkg::SPAN_W-2:0]        span_mag_q;
	logic                                neg_q;
	logic [jamdl_pkg::RAW_W-1:0]         dsr_q;
	logic [jamdl_pkg::DVD_W-1:0]         dvd_q;
	logic [jamdl_pkg::RAW_W-1:0]         rem_q;
	logic signed [jamdl_pkg::SUM_W-1:0]  sum_q;

	// per-pass results
	logic signed [jamdl_pkg::AXIS_W-1:0] x_axis_q, y_axis_q;
	logic signed [jamdl_pkg::CRS_W-1:0]  cx_q, cy_q;

	// direction state
	jamdl_pkg::dir_t                     pending_q, latched_q;

	// output register
	logic                                out_valid_q;
	logic signed [jamdl_pkg::AXIS_W-1:0] out_x_q, out_y_q;
	jamdl_pkg::dir_t                     out_dir_q;

	// pass operand selection
	logic                                op_y, op_coarse;
	logic [jamdl_pkg::RAW_W-1:0]         raw_sel, ctr_sel;
	logic                                flip_sel;
	logic signed [jamdl_pkg::AXIS_W-1:0] lo_sel, hi_sel;

	assign op_y = (cmd.op == jamdl_pkg::OP_Y_FINE) || (cmd.op == jamdl_pkg::OP_Y_COARSE);
	assign op_coarse = (cmd.op == jamdl_pkg::OP_X_COARSE) ||
		(cmd.op == jamdl_pkg::OP_Y_COARSE);
	assign raw_sel  = op_y ? y_raw_q : x_raw_q;
	assign ctr_sel  = op_y ? y_center_q : x_center_q;
	assign flip_sel = op_y ? y_flip_q : x_flip_q;
	assign lo_sel   = op_coarse ? jamdl_pkg::COARSE_LO : range_min_q;
	assign hi_sel   = op_coarse ? jamdl_pkg::COARSE_HI : range_max_q;

	assign cfg_ready = 1'b1;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_center_q  <= 10'd512;
			y_center_q  <= 10'd512;
			x_flip_q    <= 1'b0;
			y_flip_q    <= 1'b0;
			range_min_q <= -16'sd500;
			range_max_q <= 16'sd500;
		end else if (cfg_valid) begin
			case (cfg_index)
				jamdl_pkg::CFG_X_CENTER:  x_center_q  <= cfg_data[jamdl_pkg::RAW_W-1:0];
				jamdl_pkg::CFG_Y_CENTER:  y_center_q  <= cfg_data[jamdl_pkg::RAW_W-1:0];
				jamdl_pkg::CFG_X_FLIP:    x_flip_q    <= cfg_data[0];
				jamdl_pkg::CFG_Y_FLIP:    y_flip_q    <= cfg_data[0];
				jamdl_pkg::CFG_RANGE_MIN: range_min_q <= $signed(cfg_data);
				jamdl_pkg::CFG_RANGE_MAX: range_max_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= kind;
			x_raw_q   <= x_raw;
			y_raw_q   <= y_raw;
			sel_lvl_q <= select_level;
		end
	end

	assign stat.kind     = kind_q;
	assign stat.out_free = !out_valid_q || out_ready;

	// prep: limit, divisor, operand magnitudes and sign
	logic [jamdl_pkg::RAW_W-1:0]         lim_alt, limit;
	logic signed [jamdl_pkg::OFS_W-1:0]  ofs, ofs_abs;
	logic signed [jamdl_pkg::SPAN_W-1:0] span, span_abs;

	always_comb begin
		lim_alt  = jamdl_pkg::RAW_MAX - ctr_sel;
		limit    = (ctr_sel < lim_alt) ? ctr_sel : lim_alt;
		ofs      = $signed({2'b00, raw_sel}) - $signed({2'b00, ctr_sel})
			+ $signed({2'b00, limit});
		ofs_abs  = ofs[jamdl_pkg::OFS_W-1] ? -ofs : ofs;
		span     = $signed({{2{hi_sel[jamdl_pkg::AXIS_W-1]}}, hi_sel})
			- $signed({{2{lo_sel[jamdl_pkg::AXIS_W-1]}}, lo_sel})
			+ jamdl_pkg::SPAN_W'(1);
		span_abs = span[jamdl_pkg::SPAN_W-1] ? -span : span;
	end

	// divider step: two restoring steps per cycle
	logic [jamdl_pkg::DVD_W-1:0] dvd_nx;
	logic [jamdl_pkg::RAW_W-1:0] rem_nx;
	logic [jamdl_pkg::RAW_W:0]   trial;

	always_comb begin
		dvd_nx = dvd_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < jamdl_pkg::RADIX_BITS; i++) begin
			trial  = {rem_nx, dvd_nx[jamdl_pkg::DVD_W-1]};
			dvd_nx = {dvd_nx[jamdl_pkg::DVD_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_nx    = jamdl_pkg::RAW_W'(trial - {1'b0, dsr_q});
				dvd_nx[0] = 1'b1;
			end else begin
				rem_nx = trial[jamdl_pkg::RAW_W-1:0];
			end
		end
	end

	// multiply, divide and signed sum
	logic [jamdl_pkg::DVD_W:0]          prod;
	logic signed [jamdl_pkg::QUO_W-1:0] quo;

	assign prod = ofs_mag_q * span_mag_q;
	assign quo  = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			ofs_mag_q  <= ofs_abs[jamdl_pkg::RAW_W-1:0];
			span_mag_q <= span_abs[jamdl_pkg::SPAN_W-2:0];
			neg_q      <= ofs[jamdl_pkg::OFS_W-1] ^ span[jamdl_pkg::SPAN_W-1];
			dsr_q      <= {limit[jamdl_pkg::RAW_W-2:0], 1'b1};
		end
		if (cmd.mul) begin
			rem_q <= '0;
			if (op_coarse) dvd_q <= prod[jamdl_pkg::DVD_W-1:0] << jamdl_pkg::COARSE_SHIFT;
			else dvd_q <= prod[jamdl_pkg::DVD_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_nx;
		end
		if (cmd.add) begin
			sum_q <= jamdl_pkg::SUM_W'(quo) + jamdl_pkg::SUM_W'(lo_sel);
		end
	end

	// clamp to bounds, then optional negate with saturation
	logic signed [jamdl_pkg::AXIS_W-1:0] clamped, mapped;

	always_comb begin
		if (sum_q < jamdl_pkg::SUM_W'(lo_sel)) clamped = lo_sel;
		else if (sum_q > jamdl_pkg::SUM_W'(hi_sel)) clamped = hi_sel;
		else clamped = sum_q[jamdl_pkg::AXIS_W-1:0];
		if (!flip_sel) mapped = clamped;
		else if (clamped == jamdl_pkg::AXIS_NEG_MAX) mapped = jamdl_pkg::AXIS_POS_MAX;
		else mapped = -clamped;
	end

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			case (cmd.op)
				jamdl_pkg::OP_X_FINE:   x_axis_q <= mapped;
				jamdl_pkg::OP_Y_FINE:   y_axis_q <= mapped;
				jamdl_pkg::OP_X_COARSE: cx_q     <= mapped[jamdl_pkg::CRS_W-1:0];
				jamdl_pkg::OP_Y_COARSE: cy_q     <= mapped[jamdl_pkg::CRS_W-1:0];
				default: ;
			endcase
		end
	end

	// direction rules, later ones win
	jamdl_pkg::dir_t dir_nx;
	logic            centered;

	always_comb begin
		dir_nx = pending_q;
		if (cx_q < jamdl_pkg::TRIP_LO) dir_nx = jamdl_pkg::DIR_LEFT;
		if (cx_q > jamdl_pkg::TRIP_HI) dir_nx = jamdl_pkg::DIR_RIGHT;
		if (cy_q < jamdl_pkg::TRIP_LO) dir_nx = jamdl_pkg::DIR_DOWN;
		if (cy_q > jamdl_pkg::TRIP_HI) dir_nx = jamdl_pkg::DIR_UP;
		if (!sel_lvl_q) dir_nx = jamdl_pkg::DIR_SELECT;
		centered = (cx_q == '0) && (cy_q == '0) && sel_lvl_q;
	end

	// direction state update on result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= jamdl_pkg::DIR_NONE;
			latched_q <= jamdl_pkg::DIR_NONE;
		end else if (cmd.emit) begin
			if (kind_q) begin
				if (latched_q != jamdl_pkg::DIR_NONE) begin
					pending_q <= jamdl_pkg::DIR_NONE;
					latched_q <= jamdl_pkg::DIR_NONE;
				end
			end else if (centered) begin
				latched_q <= dir_nx;
				pending_q <= jamdl_pkg::DIR_NONE;
			end else begin
				pending_q <= dir_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (kind_q) begin
				out_x_q   <= '0;
				out_y_q   <= '0;
				out_dir_q <= latched_q;
			end else begin
				out_x_q   <= x_axis_q;
				out_y_q   <= y_axis_q;
				out_dir_q <= jamdl_pkg::DIR_NONE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign x_axis    = out_x_q;
	assign y_axis    = out_y_q;
	assign direction = out_dir_q;

	// terms for the checks below
	logic read_hit, dir_clear, crs_in_range;

	assign read_hit     = cmd.emit && kind_q && (latched_q != jamdl_pkg::DIR_NONE);
	assign dir_clear    = (latched_q == jamdl_pkg::DIR_NONE) &&
		(pending_q == jamdl_pkg::DIR_NONE);
	assign crs_in_range = (cx_q >= jamdl_pkg::CRS_MIN) && (cx_q <= jamdl_pkg::CRS_MAX) &&
		(cy_q >= jamdl_pkg::CRS_MIN) && (cy_q <= jamdl_pkg::CRS_MAX);

	`JAMDL_ASSERT_IMP(a_rem_below_dsr, cmd.div_step, rem_q < dsr_q, "remainder not below divisor")
	`JAMDL_ASSERT_NXT(a_read_consumes, read_hit, dir_clear, "read did not clear direction")
	`JAMDL_ASSERT_IMP(a_coarse_range, cmd.emit && !kind_q, crs_in_range, "coarse axis out of range")

endmodule

### bench/joystick_axis_map_direction_latch_unit_tb.sv
module joystick_axis_map_direction_latch_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_READ    = 1'b1;
	localparam int   LIMIT_CYCLES = 1000000;
	localparam int   HOLD_CYCLES  = 600;
	localparam int   PHASE_BEATS  = 200;
	localparam int   TAIL_CYCLES  = 80;

	// which coarse zone a picked reading should land in
	typedef enum int {
		AIM_REST,
		AIM_LOW,
		AIM_HIGH,
		AIM_ANY
	} aim_t;

	typedef struct {
		logic signed [jamdl_pkg::AXIS_W-1:0] x_val;
		logic signed [jamdl_pkg::AXIS_W-1:0] y_val;
		jamdl_pkg::dir_t                     dir;
	} axis_result_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_ready;
	logic                                   kind;
	logic [jamdl_pkg::RAW_W-1:0]            x_raw;
	logic [jamdl_pkg::RAW_W-1:0]            y_raw;
	logic                                   select_level;
	logic                                   cfg_valid;
	logic                                   cfg_ready;
	logic [jamdl_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [jamdl_pkg::AXIS_W-1:0]           cfg_data;
	logic                                   out_valid;
	logic                                   out_ready;
	logic signed [jamdl_pkg::AXIS_W-1:0]    x_axis;
	logic signed [jamdl_pkg::AXIS_W-1:0]    y_axis;
	logic [jamdl_pkg::DIR_W-1:0]            direction;

	// predictor copy of registers and direction state
	logic [jamdl_pkg::RAW_W-1:0]            x_ctr;
	logic [jamdl_pkg::RAW_W-1:0]            y_ctr;
	logic                                   x_flp;
	logic                                   y_flp;
	logic signed [jamdl_pkg::AXIS_W-1:0]    rng_lo;
	logic signed [jamdl_pkg::AXIS_W-1:0]    rng_hi;
	jamdl_pkg::dir_t                        pend_dir;
	jamdl_pkg::dir_t                        latch_dir;

	axis_result_t                           mapped_q[$];
	bit                                     idle_en;
	bit                                     hold_req;
	int                                     fail_count;
	int                                     cycle_count;
	int                                     beats_sent;

	joystick_axis_map_direction_latch_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.x_raw        (x_raw),
		.y_raw        (y_raw),
		.select_level (select_level),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.x_axis       (x_axis),
		.y_axis       (y_axis),
		.direction    (direction)
	);

	always #5 clk = ~clk;

	// map one reading around its centre onto lo..hi, clamp, then optional flip
	function automatic int map_reading(logic [jamdl_pkg::RAW_W-1:0] raw,
			logic [jamdl_pkg::RAW_W-1:0] ctr, logic flip, int lo, int hi);
		longint c;
		longint r;
		longint lim;
		longint num;
		longint v;
		int     res;
		c   = longint'(ctr);
		r   = longint'(raw);
		lim = (c < 1023 - c) ? c : 1023 - c;
		num = (r - c + lim) * (longint'(hi) - longint'(lo) + 1);
		v   = num / (2 * lim + 1) + longint'(lo);
		if (v < lo) begin
			res = lo;
		end else if (v > hi) begin
			res = hi;
		end else begin
			res = int'(v);
		end
		if (flip) begin
			res = (res == -32768) ? 32767 : -res;
		end
		return res;
	endfunction

	// advance the direction state for one beat and queue its result
	function automatic void apply_beat(logic k, logic [jamdl_pkg::RAW_W-1:0] xr,
			logic [jamdl_pkg::RAW_W-1:0] yr, logic sel);
		axis_result_t res;
		int           cx;
		int           cy;
		if (k == KIND_READ) begin
			res.x_val = '0;
			res.y_val = '0;
			res.dir   = latch_dir;
			if (latch_dir != jamdl_pkg::DIR_NONE) begin
				latch_dir = jamdl_pkg::DIR_NONE;
				pend_dir  = jamdl_pkg::DIR_NONE;
			end
		end else begin
			res.x_val = 16'(map_reading(xr, x_ctr, x_flp, int'(rng_lo), int'(rng_hi)));
			res.y_val = 16'(map_reading(yr, y_ctr, y_flp, int'(rng_lo), int'(rng_hi)));
			res.dir   = jamdl_pkg::DIR_NONE;
			cx = map_reading(xr, x_ctr, x_flp, int'(jamdl_pkg::COARSE_LO),
				int'(jamdl_pkg::COARSE_HI));
			cy = map_reading(yr, y_ctr, y_flp, int'(jamdl_pkg::COARSE_LO),
				int'(jamdl_pkg::COARSE_HI));
			if (cx < int'(jamdl_pkg::TRIP_LO)) pend_dir = jamdl_pkg::DIR_LEFT;
			if (cx > int'(jamdl_pkg::TRIP_HI)) pend_dir = jamdl_pkg::DIR_RIGHT;
			if (cy < int'(jamdl_pkg::TRIP_LO)) pend_dir = jamdl_pkg::DIR_DOWN;
			if (cy > int'(jamdl_pkg::TRIP_HI)) pend_dir = jamdl_pkg::DIR_UP;
			if (!sel) pend_dir = jamdl_pkg::DIR_SELECT;
			if (cx == 0 && cy == 0 && sel) begin
				latch_dir = pend_dir;
				pend_dir  = jamdl_pkg::DIR_NONE;
			end
		end
		mapped_q.push_back(res);
	endfunction

	// scan from a random start for a reading whose coarse value hits the zone
	function automatic logic [jamdl_pkg::RAW_W-1:0] pick_raw(
			logic [jamdl_pkg::RAW_W-1:0] ctr, logic flip, aim_t aim);
		int                          start;
		int                          c;
		logic [jamdl_pkg::RAW_W-1:0] raw;
		start = $urandom_range(0, 1023);
		if (aim == AIM_ANY) return 10'(start);
		for (int i = 0; i < 1024; i++) begin
			raw = 10'((start + i) % 1024);
			c = map_reading(raw, ctr, flip, int'(jamdl_pkg::COARSE_LO),
				int'(jamdl_pkg::COARSE_HI));
			if ((aim == AIM_REST && c == 0) ||
					(aim == AIM_LOW && c < int'(jamdl_pkg::TRIP_LO)) ||
					(aim == AIM_HIGH && c > int'(jamdl_pkg::TRIP_HI)))
				return raw;
		end
		return 10'(start);
	endfunction

	// one input beat; valid stays up after acceptance until the next falling edge
	task automatic send_beat(input logic k, input logic [jamdl_pkg::RAW_W-1:0] xr,
			input logic [jamdl_pkg::RAW_W-1:0] yr, input logic sel);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		kind         = k;
		x_raw        = xr;
		y_raw        = yr;
		select_level = sel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		apply_beat(k, xr, yr, sel);
		beats_sent++;
	endtask

	task automatic send_read();
		send_beat(KIND_READ, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic send_aimed(input aim_t ax, input aim_t ay, input logic sel);
		send_beat(KIND_SAMPLE, pick_raw(x_ctr, x_flp, ax), pick_raw(y_ctr, y_flp, ay), sel);
	endtask

	// wait out every queued result with the input channel quiet
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (mapped_q.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input jamdl_pkg::cfg_idx_t idx,
			input logic [jamdl_pkg::AXIS_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			jamdl_pkg::CFG_X_CENTER:  x_ctr  = data[jamdl_pkg::RAW_W-1:0];
			jamdl_pkg::CFG_Y_CENTER:  y_ctr  = data[jamdl_pkg::RAW_W-1:0];
			jamdl_pkg::CFG_X_FLIP:    x_flp  = data[0];
			jamdl_pkg::CFG_Y_FLIP:    y_flp  = data[0];
			jamdl_pkg::CFG_RANGE_MIN: rng_lo = data;
			jamdl_pkg::CFG_RANGE_MAX: rng_hi = data;
			default: ;
		endcase
	endtask

	// full register load while idle; unused upper bits get random junk
	task automatic set_config(input logic [jamdl_pkg::RAW_W-1:0] xc,
			input logic [jamdl_pkg::RAW_W-1:0] yc,
			input logic xf, input logic yf, input logic [jamdl_pkg::AXIS_W-1:0] lo,
			input logic [jamdl_pkg::AXIS_W-1:0] hi);
		logic [jamdl_pkg::AXIS_W-1:0] junk;
		drain_results();
		junk = 16'($urandom);
		write_reg(jamdl_pkg::CFG_X_CENTER, {junk[15:10], xc});
		junk = 16'($urandom);
		write_reg(jamdl_pkg::CFG_Y_CENTER, {junk[15:10], yc});
		junk = 16'($urandom);
		write_reg(jamdl_pkg::CFG_X_FLIP, {junk[15:1], xf});
		junk = 16'($urandom);
		write_reg(jamdl_pkg::CFG_Y_FLIP, {junk[15:1], yf});
		write_reg(jamdl_pkg::CFG_RANGE_MIN, lo);
		write_reg(jamdl_pkg::CFG_RANGE_MAX, hi);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [jamdl_pkg::RAW_W-1:0] rand_center();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14) return 10'($urandom_range(300, 723));
		if (pick == 14) return 10'd0;
		if (pick == 15) return 10'd1023;
		if (pick == 16) return 10'($urandom_range(1, 6));
		return 10'($urandom_range(0, 1023));
	endfunction

	task automatic randomize_config();
		logic [jamdl_pkg::AXIS_W-1:0] lo;
		logic [jamdl_pkg::AXIS_W-1:0] hi;
		int                           pick;
		pick = $urandom_range(0, 19);
		if (pick < 10) begin
			// any pair, reversed bounds included
			lo = 16'($urandom);
			hi = 16'($urandom);
		end else if (pick < 14) begin
			hi = 16'($urandom_range(0, 2000));
			lo = -hi;
		end else if (pick < 17) begin
			lo = 16'sh8000;
			hi = 16'sh7fff;
		end else begin
			lo = -16'sd500;
			hi = 16'sd500;
		end
		set_config(rand_center(), rand_center(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), lo, hi);
	endtask

	// push the stick around, return it to rest, usually read the latch
	task automatic send_gesture();
		int moves;
		moves = $urandom_range(1, 4);
		repeat (moves) begin
			send_aimed(aim_t'($urandom_range(0, 3)), aim_t'($urandom_range(0, 3)),
				$urandom_range(0, 4) != 0);
		end
		send_aimed(AIM_REST, AIM_REST, 1'b1);
		if ($urandom_range(0, 9) < 6) send_read();
	endtask

	task automatic send_noise();
		if ($urandom_range(0, 9) < 3) begin
			send_read();
		end else begin
			send_beat(KIND_SAMPLE, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
				1'($urandom_range(0, 1)));
		end
	endtask

	// ---- directed tests ----

	task automatic test_reset_defaults();
		send_beat(KIND_SAMPLE, 10'd0, 10'd1023, 1'b1);
		send_beat(KIND_SAMPLE, 10'd1023, 10'd0, 1'b0);
		send_beat(KIND_SAMPLE, 10'd512, 10'd512, 1'b1);
		send_read();
		send_read();
	endtask

	task automatic test_directions();
		send_aimed(AIM_LOW, AIM_REST, 1'b1);
		send_aimed(AIM_REST, AIM_REST, 1'b1);
		send_read();
		// a read of a latched direction also drops the pending one
		send_aimed(AIM_HIGH, AIM_REST, 1'b1);
		send_aimed(AIM_REST, AIM_REST, 1'b1);
		send_aimed(AIM_REST, AIM_LOW, 1'b1);
		send_read();
		send_aimed(AIM_REST, AIM_REST, 1'b1);
		send_read();
		// Y outranks X when both are deflected
		send_aimed(AIM_LOW, AIM_HIGH, 1'b1);
		send_aimed(AIM_REST, AIM_REST, 1'b1);
		send_read();
	endtask

	task automatic test_edge_centers();
		// centre at 0 or 1023 leaves no room on one side; divisor is 1
		set_config(10'd0, 10'd1023, 1'b1, 1'b0, -16'sd500, 16'sd500);
		send_beat(KIND_SAMPLE, 10'd0, 10'd0, 1'b1);
		send_beat(KIND_SAMPLE, 10'd1023, 10'd1023, 1'b1);
		send_beat(KIND_SAMPLE, 10'd1, 10'd1022, 1'b0);
	endtask

	task automatic test_bounds();
		// reversed bounds: min wins below, max everywhere else
		set_config(10'd512, 10'd512, 1'b0, 1'b1, 16'sd100, -16'sd100);
		send_beat(KIND_SAMPLE, 10'd0, 10'd1023, 1'b1);
		send_beat(KIND_SAMPLE, 10'd512, 10'd0, 1'b1);
		send_beat(KIND_SAMPLE, 10'd1023, 10'd512, 1'b1);
		// full range with flip: the most negative value saturates
		set_config(10'd512, 10'd512, 1'b1, 1'b1, 16'sh8000, 16'sh7fff);
		send_beat(KIND_SAMPLE, 10'd0, 10'd1023, 1'b1);
		send_beat(KIND_SAMPLE, 10'd1023, 10'd0, 1'b0);
	endtask

	task automatic test_backpressure();
		drain_results();
		idle_en  = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 0) send_read();
			else send_noise();
		end
		drain_results();
	endtask

	task automatic test_random_traffic();
		int target;
		for (int ph = 0; ph < 9; ph++) begin
			randomize_config();
			idle_en = (ph == 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target) begin
				if ($urandom_range(0, 9) < 7) send_gesture();
				else send_noise();
			end
			drain_results();
		end
	endtask

	// ---- result side ----

	// receiver stalls: random bursts, or one long counted hold on request
	initial begin : result_ready
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				for (n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				n = $urandom_range(1, 17);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// compare every accepted result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		axis_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (mapped_q.size() == 0) begin
				$display("%0t: result beat with nothing expected: x %0d y %0d dir %0d",
					$time, x_axis, y_axis, direction);
				fail_count++;
			end else begin
				want = mapped_q.pop_front();
				if (x_axis !== want.x_val) begin
					$display("%0t: x_axis expected %0d got %0d", $time, want.x_val, x_axis);
					fail_count++;
				end
				if (y_axis !== want.y_val) begin
					$display("%0t: y_axis expected %0d got %0d", $time, want.y_val, y_axis);
					fail_count++;
				end
				if (direction !== want.dir) begin
					$display("%0t: direction expected %0d got %0d", $time, want.dir, direction);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, mapped_q.size());
			$display("joystick_axis_map_direction_latch_unit_tb: FAIL");
			$finish;
		end
	end

	// ---- main sequence ----
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_SAMPLE;
		x_raw        = '0;
		y_raw        = '0;
		select_level = 1'b1;
		cfg_valid    = 1'b0;
		cfg_index    = jamdl_pkg::CFG_X_CENTER;
		cfg_data     = '0;
		x_ctr        = 10'd512;
		y_ctr        = 10'd512;
		x_flp        = 1'b0;
		y_flp        = 1'b0;
		rng_lo       = -16'sd500;
		rng_hi       = 16'sd500;
		pend_dir     = jamdl_pkg::DIR_NONE;
		latch_dir    = jamdl_pkg::DIR_NONE;
		idle_en      = 1'b1;
		hold_req     = 1'b0;
		fail_count   = 0;
		cycle_count  = 0;
		beats_sent   = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_reset_defaults();
		test_directions();
		test_edge_centers();
		test_bounds();
		test_backpressure();
		test_random_traffic();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("joystick_axis_map_direction_latch_unit_tb: PASS");
		end else begin
			$display("joystick_axis_map_direction_latch_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
